FILE: hw/rtl/assert_macros.svh
// assert_macros.svh: shared assertion macros for the checker files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define SDTD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define SDTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sdtd_pkg.sv
// sdtd_pkg: types, codes and constants of the supply-drop terminate detector.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sdtd_pkg;

  localparam int VOLT_W   = 12;
  localparam int TIME_W   = 32;
  localparam int DUR_W    = 16;
  localparam int PERIOD_W = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;  // 12 + 32 bits, padded to whole bytes
  localparam int OUT_DATA_W = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_TIME = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_TIME = 8'd3;

  // Reset values of the registers
  localparam logic [VOLT_W-1:0] HIGH_THR_RST  = 12'd2350;
  localparam logic [VOLT_W-1:0] LOW_THR_RST   = 12'd1800;
  localparam logic [DUR_W-1:0]  ARM_TIME_RST  = 16'd2048;
  localparam logic [DUR_W-1:0]  FIRE_TIME_RST = 16'd2048;

  // Blink periods of the fault LED
  localparam logic [PERIOD_W-1:0] BLINK_NONE = 10'd0;
  localparam logic [PERIOD_W-1:0] BLINK_FAST = 10'd256;
  localparam logic [PERIOD_W-1:0] BLINK_SLOW = 10'd512;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ARMING = 2'd1,
    PH_ARMED  = 2'd2,
    PH_FIRING = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    LED_KEEP  = 2'd0,
    LED_OFF   = 2'd1,
    LED_FLASH = 2'd2
  } led_action_t;

  typedef struct packed {
    logic [VOLT_W-1:0] high_threshold;
    logic [VOLT_W-1:0] low_threshold;
    logic [DUR_W-1:0]  arm_time;
    logic [DUR_W-1:0]  fire_time;
  } cfg_t;

  // Packed so that terminate sits in bit 0, phase in the top bits
  typedef struct packed {
    phase_t              phase;
    logic                operate_led_off;
    logic [PERIOD_W-1:0] blink_period;
    led_action_t         fault_led_action;
    logic                terminate;
  } result_t;

  // Next-state bundle from the step logic to the state registers
  typedef struct packed {
    phase_t phase;
    logic   load_start;
  } step_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sdtd_cfg_regs.sv
// sdtd_cfg_regs: threshold and timing registers written over the config channel.
// Depends on sdtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdtd_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [sdtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sdtd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sdtd_pkg::cfg_t                         cfg_o
);

  sdtd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        sdtd_pkg::REG_HIGH_THR:  cfg_nxt.high_threshold = cfg_data[sdtd_pkg::VOLT_W-1:0];
        sdtd_pkg::REG_LOW_THR:   cfg_nxt.low_threshold  = cfg_data[sdtd_pkg::VOLT_W-1:0];
        sdtd_pkg::REG_ARM_TIME:  cfg_nxt.arm_time       = cfg_data[sdtd_pkg::DUR_W-1:0];
        sdtd_pkg::REG_FIRE_TIME: cfg_nxt.fire_time      = cfg_data[sdtd_pkg::DUR_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_threshold <= sdtd_pkg::HIGH_THR_RST;
      cfg_r.low_threshold  <= sdtd_pkg::LOW_THR_RST;
      cfg_r.arm_time       <= sdtd_pkg::ARM_TIME_RST;
      cfg_r.fire_time      <= sdtd_pkg::FIRE_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sdtd_step.sv
// sdtd_step: combinational phase step for one voltage sample.
// Depends on sdtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdtd_step (
  input  wire sdtd_pkg::phase_t                phase_i,
  input  wire logic [sdtd_pkg::TIME_W-1:0]     start_time_i,
  input  wire logic [sdtd_pkg::VOLT_W-1:0]     voltage_i,
  input  wire logic [sdtd_pkg::TIME_W-1:0]     now_i,
  input  wire sdtd_pkg::cfg_t                  cfg_i,
  output sdtd_pkg::result_t                    result_o,
  output sdtd_pkg::step_ctl_t                  ctl_o
);

  logic [sdtd_pkg::TIME_W-1:0] elapsed;
  logic                        above_high;
  logic                        below_high;
  logic                        below_low;
  logic                        arm_done;
  logic                        fire_done;

  // Wrapping difference; the 32-bit subtract drops the borrow by itself
  assign elapsed    = now_i - start_time_i;
  assign above_high = voltage_i > cfg_i.high_threshold;
  assign below_high = voltage_i < cfg_i.high_threshold;
  assign below_low  = voltage_i < cfg_i.low_threshold;
  assign arm_done   = elapsed >= {{(sdtd_pkg::TIME_W-sdtd_pkg::DUR_W){1'b0}}, cfg_i.arm_time};
  assign fire_done  = elapsed >= {{(sdtd_pkg::TIME_W-sdtd_pkg::DUR_W){1'b0}}, cfg_i.fire_time};

  always_comb begin
    result_o.terminate        = 1'b0;
    result_o.fault_led_action = sdtd_pkg::LED_KEEP;
    result_o.blink_period     = sdtd_pkg::BLINK_NONE;
    result_o.operate_led_off  = 1'b0;
    ctl_o.phase               = phase_i;
    ctl_o.load_start          = 1'b0;
    case (phase_i)
      sdtd_pkg::PH_IDLE: begin
        if (above_high) begin
          ctl_o.phase               = sdtd_pkg::PH_ARMING;
          ctl_o.load_start          = 1'b1;
          result_o.fault_led_action = sdtd_pkg::LED_FLASH;
          result_o.blink_period     = sdtd_pkg::BLINK_FAST;
        end
      end
      sdtd_pkg::PH_ARMING: begin
        if (above_high) begin
          if (arm_done) begin
            ctl_o.phase               = sdtd_pkg::PH_ARMED;
            result_o.fault_led_action = sdtd_pkg::LED_OFF;
          end
        end else begin
          ctl_o.phase               = sdtd_pkg::PH_IDLE;
          result_o.fault_led_action = sdtd_pkg::LED_FLASH;
          result_o.blink_period     = sdtd_pkg::BLINK_SLOW;
        end
      end
      sdtd_pkg::PH_ARMED: begin
        if (below_low) begin
          ctl_o.phase               = sdtd_pkg::PH_FIRING;
          ctl_o.load_start          = 1'b1;
          result_o.fault_led_action = sdtd_pkg::LED_FLASH;
          result_o.blink_period     = sdtd_pkg::BLINK_FAST;
        end
      end
      default: begin
        // Firing compares against the high threshold, not the low one
        if (below_high) begin
          if (fire_done) begin
            ctl_o.phase               = sdtd_pkg::PH_IDLE;
            result_o.terminate        = 1'b1;
            result_o.fault_led_action = sdtd_pkg::LED_FLASH;
            result_o.blink_period     = sdtd_pkg::BLINK_SLOW;
          end
        end else begin
          ctl_o.phase              = sdtd_pkg::PH_ARMED;
          result_o.operate_led_off = 1'b1;
        end
      end
    endcase
    result_o.phase = ctl_o.phase;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/supply_drop_terminate_detector.sv
// supply_drop_terminate_detector: top level of the supply-drop terminate detector.
// Depends on sdtd_pkg, sdtd_cfg_regs and sdtd_step.
//
//   Channel  Dir  Handshake             Payload
//   in_      in   in_tvalid/in_tready   tdata: voltage[11:0], now[43:12], zero pad
//   out_     out  out_tvalid/out_tready tdata: terminate, led action, period, op off, phase
//   cfg_     in   cfg_valid/cfg_ready   cfg_index selects register, cfg_data holds value
//
// Throughput is one beat per cycle unless out_tready stalls; beats pass the input register,
// then the result register, with the phase step between as one subtract and compares.
// Reset (rst_n low, synchronous) clears the phase to idle, the start time to zero,
// the registers to their defaults and both valid flags.
// A stalled output holds its beat; the input register keeps accepting as long as
// its beat can move into the result register in the same cycle.
// Configuration writes are always accepted and take effect at the next edge.
`timescale 1ns / 1ps
`default_nettype none

module supply_drop_terminate_detector (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input samples
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [11:0] voltage, [43:12] now, [47:44] zero
  input  wire logic [sdtd_pkg::IN_DATA_W-1:0]    in_tdata,
  // Results
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] terminate, [2:1] fault_led_action, [12:3] blink_period,
  // [13] operate_led_off, [15:14] phase
  output logic [sdtd_pkg::OUT_DATA_W-1:0]        out_tdata,
  // Register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sdtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sdtd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sdtd_pkg::cfg_t      cfg;
  sdtd_pkg::result_t   step_result;
  sdtd_pkg::step_ctl_t step_ctl;

  // Input stage
  logic                          s1_valid_r, s1_valid_nxt;
  logic [sdtd_pkg::VOLT_W-1:0]   s1_voltage_r;
  logic [sdtd_pkg::TIME_W-1:0]   s1_now_r;

  // Detector state
  sdtd_pkg::phase_t              phase_r, phase_nxt;
  logic [sdtd_pkg::TIME_W-1:0]   start_time_r, start_time_nxt;

  // Result stage
  logic                          out_valid_r, out_valid_nxt;
  sdtd_pkg::result_t             result_r;

  logic s1_advance;
  logic in_take;

  // The input beat moves on when the result register is empty or being drained
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_take    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  sdtd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  sdtd_step u_step (
    .phase_i      (phase_r),
    .start_time_i (start_time_r),
    .voltage_i    (s1_voltage_r),
    .now_i        (s1_now_r),
    .cfg_i        (cfg),
    .result_o     (step_result),
    .ctl_o        (step_ctl)
  );

  always_comb begin
    s1_valid_nxt   = in_take || (s1_valid_r && !s1_advance);
    out_valid_nxt  = s1_advance || (out_valid_r && !out_tready);
    // Commit the step only when its beat lands in the result register
    phase_nxt      = s1_advance ? step_ctl.phase : phase_r;
    start_time_nxt = (s1_advance && step_ctl.load_start) ? s1_now_r : start_time_r;
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= sdtd_pkg::PH_IDLE;
      start_time_r <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      start_time_r <= start_time_nxt;
    end
  end

  // Payload: load on take, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_voltage_r <= in_tdata[sdtd_pkg::VOLT_W-1:0];
      s1_now_r     <= in_tdata[sdtd_pkg::VOLT_W +: sdtd_pkg::TIME_W];
    end
    if (s1_advance) begin
      result_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sdtd_checker.sv
// sdtd_checker: port-level assertions for the detector, bound to its top level.
// Depends on sdtd_pkg, assert_macros.svh and supply_drop_terminate_detector.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sdtd_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [sdtd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // A terminate beat always leaves the detector in idle
  `SDTD_ASSERT_NOW(a_term_idle, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[15:14] == sdtd_pkg::PH_IDLE, "terminate without return to idle")

  // An aborted fire always lands in armed
  `SDTD_ASSERT_NOW(a_abort_armed, clk, rst_n, out_tvalid && out_tdata[13], out_tdata[15:14] == sdtd_pkg::PH_ARMED, "operate LED off outside armed")

  // A blink period is given exactly when the LED is told to blink
  `SDTD_ASSERT_NOW(a_blink_period, clk, rst_n, out_tvalid, (out_tdata[2:1] == sdtd_pkg::LED_FLASH) == (out_tdata[12:3] != sdtd_pkg::BLINK_NONE), "blink period does not match LED action")

  // A stalled result holds its beat
  `SDTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind supply_drop_terminate_detector sdtd_checker u_sdtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
